// ===== rtl/w2u_pkg.sv =====
// Shared types and constants for the wide-to-UTF-8 encoder.
`default_nettype none

package w2u_pkg;

   // Source formats held in the format register.
   localparam logic [1:0] FMT_UTF16 = 2'd0;
   localparam logic [1:0] FMT_UCS2  = 2'd1;
   localparam logic [1:0] FMT_UTF32 = 2'd2;
   localparam logic [1:0] FMT_UCS4  = 2'd3;

   localparam logic [31:0] CP_REPLACEMENT = 32'h0000_FFFD;
   localparam logic [31:0] BOM_16         = 32'h0000_FEFF;
   localparam logic [31:0] BOM_16_SWAPPED = 32'h0000_FFFE;
   localparam logic [31:0] BOM_32         = 32'h0000_FEFF;
   localparam logic [31:0] BOM_32_SWAPPED = 32'hFFFE_0000;
   localparam logic [31:0] SURR_HIGH_LO   = 32'h0000_D800;
   localparam logic [31:0] SURR_HIGH_HI   = 32'h0000_DBFF;
   localparam logic [31:0] SURR_LOW_LO    = 32'h0000_DC00;
   localparam logic [31:0] SURR_LOW_HI    = 32'h0000_DFFF;
   localparam logic [31:0] SUPPLEMENTARY  = 32'h0001_0000;
   localparam logic [31:0] UNICODE_LIMIT  = 32'h0011_0000;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One code point waiting to be serialized.
   typedef struct packed {
      logic [30:0] cp;
      logic        err;
      logic [2:0]  len;
   } entry_type;

endpackage

`default_nettype wire

// ===== rtl/w2u_front.sv =====
// Front end: accepts code units, tracks string state and forms code points.
`default_nettype none

module w2u_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [31:0]         req_code_unit,
   input  wire logic                req_last_unit,
   input  wire logic                csr_wr_en,
   input  wire logic [1:0]          csr_wr_data,
   input  wire logic                queue_full,
   output logic                     push,
   output w2u_pkg::entry_type       push_entry
);
   import w2u_pkg::*;

   logic [1:0]  fmt_ff, fmt_in;
   logic        at_start_ff, at_start_in;
   logic        swap_ff, swap_in;
   logic        pend_ff, pend_in;
   logic [9:0]  held_ff, held_in;

   logic        accept;
   logic        wide;
   logic [31:0] raw;
   logic        is_mark;
   logic        is_rmark;
   logic        swap_eff;
   logic        pend_eff;
   logic [31:0] u;
   logic        u_surr;
   logic        u_low;
   logic        u_high;
   logic [20:0] pair_cp;
   logic        emit_en;
   logic [31:0] cand_cp;
   logic        cand_err;
   logic        bad_cp;
   logic [30:0] final_cp;

   function automatic logic [2:0] run_length(input logic [30:0] cp);
      logic [2:0] len;
      if (cp < 31'h80) begin
         len = 3'd1;
      end else if (cp < 31'h800) begin
         len = 3'd2;
      end else if (cp < 31'h1_0000) begin
         len = 3'd3;
      end else if (cp < 31'h20_0000) begin
         len = 3'd4;
      end else if (cp < 31'h400_0000) begin
         len = 3'd5;
      end else begin
         len = 3'd6;
      end
      return len;
   endfunction

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign wide      = fmt_ff[1];
   assign raw       = wide ? req_code_unit : {16'h0000, req_code_unit[15:0]};
   assign is_mark   = wide ? (raw == BOM_32) : (raw == BOM_16);
   assign is_rmark  = wide ? (raw == BOM_32_SWAPPED) : (raw == BOM_16_SWAPPED);

   // The first word of a string starts with no swap and no held surrogate.
   assign swap_eff  = at_start_ff ? 1'b0 : swap_ff;
   assign pend_eff  = at_start_ff ? 1'b0 : pend_ff;

   always_comb begin
      if (!swap_eff) begin
         u = raw;
      end else if (wide) begin
         u = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
      end else begin
         u = {16'h0000, raw[7:0], raw[15:8]};
      end
   end

   assign u_surr  = (u >= SURR_HIGH_LO) && (u <= SURR_LOW_HI);
   assign u_low   = (u >= SURR_LOW_LO) && (u <= SURR_LOW_HI);
   assign u_high  = (u >= SURR_HIGH_LO) && (u <= SURR_HIGH_HI);
   assign pair_cp = {1'b0, held_ff, u[9:0]} + SUPPLEMENTARY[20:0];

   always_comb begin
      emit_en  = 1'b1;
      cand_cp  = u;
      cand_err = 1'b0;
      held_in  = held_ff;
      pend_in  = 1'b0;
      if (fmt_ff == FMT_UTF16) begin
         if (pend_eff) begin
            if (u_low) begin
               cand_cp = {11'b0, pair_cp};
            end else begin
               cand_cp  = CP_REPLACEMENT;
               cand_err = 1'b1;
            end
         end else if (!u_surr) begin
            cand_cp = u;
         end else if (u_high && !req_last_unit) begin
            emit_en = 1'b0;
            pend_in = 1'b1;
            held_in = u[9:0];
         end else begin
            cand_cp  = CP_REPLACEMENT;
            cand_err = 1'b1;
         end
      end else if (fmt_ff == FMT_UTF32 && u >= UNICODE_LIMIT) begin
         cand_cp  = CP_REPLACEMENT;
         cand_err = 1'b1;
      end
   end

   assign bad_cp   = ((cand_cp >= SURR_HIGH_LO) && (cand_cp <= SURR_LOW_HI)) || cand_cp[31];
   assign final_cp = bad_cp ? CP_REPLACEMENT[30:0] : cand_cp[30:0];

   assign push            = accept && !(at_start_ff && (is_mark || is_rmark)) && emit_en;
   assign push_entry.cp   = final_cp;
   assign push_entry.err  = cand_err || bad_cp;
   assign push_entry.len  = run_length(final_cp);

   always_comb begin
      fmt_in      = fmt_ff;
      at_start_in = at_start_ff;
      swap_in     = swap_ff;
      if (csr_wr_en) begin
         fmt_in = csr_wr_data;
      end
      if (accept) begin
         if (at_start_ff && (is_mark || is_rmark)) begin
            at_start_in = req_last_unit;
            swap_in     = is_rmark && !req_last_unit;
         end else begin
            at_start_in = req_last_unit;
            swap_in     = swap_eff && !req_last_unit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff      <= FMT_UTF16;
         at_start_ff <= 1'b1;
         swap_ff     <= 1'b0;
         pend_ff     <= 1'b0;
      end else begin
         fmt_ff      <= fmt_in;
         at_start_ff <= at_start_in;
         swap_ff     <= swap_in;
         if (csr_wr_en) begin
            pend_ff <= 1'b0;
         end else if (accept) begin
            // A mark drops the word; a last word closes the string.
            pend_ff <= (at_start_ff && (is_mark || is_rmark)) ? 1'b0
                                                                : (pend_in && !req_last_unit);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/w2u_queue.sv =====
// Short queue of code points between the front end and the byte serializer.
`default_nettype none

module w2u_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire w2u_pkg::entry_type  push_entry,
   input  wire logic                pop,
   output w2u_pkg::entry_type       head_entry,
   output logic                     not_empty,
   output logic                     full
);
   import w2u_pkg::*;

   entry_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] head_ff, head_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [QUEUE_PTR_W-1:0] tail;

   assign tail       = head_ff + count_ff[QUEUE_PTR_W-1:0];
   assign head_entry = mem_ff[head_ff];
   assign not_empty  = (count_ff != '0);
   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));

   always_comb begin
      head_in  = pop ? head_ff + QUEUE_PTR_W'(1) : head_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[tail] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/w2u_back.sv =====
// Back end: serializes one code point into its UTF-8 byte run.
`default_nettype none

module w2u_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire w2u_pkg::entry_type  head_entry,
   input  wire logic                not_empty,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_last_of_run,
   output logic                     rsp_replacement_error
);
   import w2u_pkg::*;

   entry_type   cur_ff, cur_in;
   logic [2:0]  rem_ff, rem_in;
   logic        valid_ff, valid_in;

   logic        take;
   logic        need_load;
   logic [35:0] cp_wide;
   logic [5:0]  chunk;

   assign take      = valid_ff && !rsp_stall;
   assign need_load = !valid_ff || (take && rem_ff == 3'd1);
   assign pop       = need_load && not_empty;

   always_comb begin
      valid_in = need_load ? not_empty : valid_ff;
      cur_in   = pop ? head_entry : cur_ff;
      if (pop) begin
         rem_in = head_entry.len;
      end else if (take) begin
         rem_in = rem_ff - 3'd1;
      end else begin
         rem_in = rem_ff;
      end
   end

   // The remaining byte count picks which six bits go out next.
   assign cp_wide = {5'b0, cur_ff.cp};

   always_comb begin
      unique case (rem_ff)
         3'd1:    chunk = cp_wide[5:0];
         3'd2:    chunk = cp_wide[11:6];
         3'd3:    chunk = cp_wide[17:12];
         3'd4:    chunk = cp_wide[23:18];
         3'd5:    chunk = cp_wide[29:24];
         3'd6:    chunk = cp_wide[35:30];
         default: chunk = 6'b0;
      endcase
   end

   always_comb begin
      if (rem_ff != cur_ff.len) begin
         rsp_out_byte = {2'b10, chunk};
      end else begin
         unique case (cur_ff.len)
            3'd1:    rsp_out_byte = {1'b0, cur_ff.cp[6:0]};
            3'd2:    rsp_out_byte = {3'b110, chunk[4:0]};
            3'd3:    rsp_out_byte = {4'b1110, chunk[3:0]};
            3'd4:    rsp_out_byte = {5'b11110, chunk[2:0]};
            3'd5:    rsp_out_byte = {6'b111110, chunk[1:0]};
            3'd6:    rsp_out_byte = {7'b1111110, chunk[0]};
            default: rsp_out_byte = 8'h00;
         endcase
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_last_of_run       = (rem_ff == 3'd1);
   assign rsp_replacement_error = cur_ff.err;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rem_ff <= rem_in;
   end

endmodule

`default_nettype wire

// ===== rtl/wide_to_utf8_encoder.sv =====
// Top level of the UTF-16/UCS-2/UTF-32/UCS-4 to UTF-8 encoder.
// Path: with the serializer idle, an accepted word is written into the queue, then loaded
// into the serializer register, which presents its first byte on the output.
// Throughput: one word per cycle while runs are one byte and rsp_stall is low; the
// serializer sends one byte per cycle unless stalled and reloads on a run's last byte.
// The two-entry queue between front end and serializer sets when req_stall rises.
// Reset (synchronous) selects UTF-16, starts a new string and empties the queue.
`default_nettype none

module wide_to_utf8_encoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_code_unit,
   input  wire logic        req_last_unit,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_of_run,
   output logic             rsp_replacement_error,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_wr_data
);
   import w2u_pkg::*;

   logic      queue_full;
   logic      push;
   entry_type push_entry;
   logic      pop;
   entry_type head_entry;
   logic      not_empty;

   w2u_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_code_unit (req_code_unit),
      .req_last_unit (req_last_unit),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .queue_full    (queue_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   w2u_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .not_empty  (not_empty),
      .full       (queue_full)
   );

   w2u_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head_entry            (head_entry),
      .not_empty             (not_empty),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_out_byte          (rsp_out_byte),
      .rsp_last_of_run       (rsp_last_of_run),
      .rsp_replacement_error (rsp_replacement_error)
   );

endmodule

`default_nettype wire

// ===== rtl/w2u_checker.sv =====
// Port-level checks on the encoder output, bound to the top level.
`default_nettype none

module w2u_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_out_byte,
   input wire logic        rsp_last_of_run,
   input wire logic        rsp_replacement_error
);

   // A stalled word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_last_of_run) && $stable(rsp_replacement_error))
      else $error("stalled output word changed");

   // Inside a run, the next byte follows at once and is a continuation byte.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run
         |=> rsp_valid && rsp_out_byte[7:6] == 2'b10)
      else $error("run broken or continuation byte malformed");

   // A plain ASCII byte is always a whole run.
   a_ascii_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_byte[7] |-> rsp_last_of_run)
      else $error("ASCII byte not at end of run");

   // An error run is U+FFFD, which ends in 0xBD.
   a_error_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_replacement_error && rsp_last_of_run |-> rsp_out_byte == 8'hBD)
      else $error("error run is not the replacement character");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("output valid right after reset");

endmodule

bind wide_to_utf8_encoder w2u_checker u_checker (.*);

`default_nettype wire

// ===== verif/wide_to_utf8_encoder_tb.sv =====
// Self-checking testbench for the wide-to-UTF-8 encoder.
`timescale 1ns / 1ps

module wide_to_utf8_encoder_tb;
   import w2u_pkg::*;

   localparam int PIPE_SETTLE    = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic [7:0] value;
      logic       run_end;
      logic       err;
   } utf8_octet_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_code_unit = '0;
   logic        req_last_unit = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_run;
   logic        rsp_replacement_error;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_wr_data = FMT_UTF16;

   utf8_octet_type expected_octets[$];
   int          send_idle_pct = 0;
   int          rsp_idle_pct = 0;
   int          fail_count = 0;
   int          words_sent = 0;
   int          octets_checked = 0;
   int          format_writes = 0;
   int          idle_cycles = 0;

   // Mirror of the encoder's string state.
   logic [1:0]  src_fmt = FMT_UTF16;
   logic        at_start = 1'b1;
   logic        swap_on = 1'b0;
   logic        hi_pending = 1'b0;
   logic [9:0]  hi_bits = '0;

   wide_to_utf8_encoder i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_code_unit         (req_code_unit),
      .req_last_unit         (req_last_unit),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_out_byte          (rsp_out_byte),
      .rsp_last_of_run       (rsp_last_of_run),
      .rsp_replacement_error (rsp_replacement_error),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Queues the UTF-8 bytes of one code point; invalid values turn into U+FFFD.
   function automatic void encode_code_point(input logic [31:0] cp_in, input logic err_in);
      logic [31:0] cp;
      logic [31:0] tail;
      logic        err;
      logic [7:0]  lead;
      int          len;
      utf8_octet_type octet;
      cp = cp_in;
      err = err_in;
      if ((cp >= SURR_HIGH_LO && cp <= SURR_LOW_HI) || cp[31]) begin
         cp = CP_REPLACEMENT;
         err = 1'b1;
      end
      if (cp < 32'h80) begin
         len = 1;
         lead = cp[7:0];
      end else if (cp < 32'h800) begin
         len = 2;
         lead = {3'b110, cp[10:6]};
      end else if (cp < SUPPLEMENTARY) begin
         len = 3;
         lead = {4'b1110, cp[15:12]};
      end else if (cp < 32'h20_0000) begin
         len = 4;
         lead = {5'b11110, cp[20:18]};
      end else if (cp < 32'h400_0000) begin
         len = 5;
         lead = {6'b111110, cp[25:24]};
      end else begin
         len = 6;
         lead = {7'b1111110, cp[30]};
      end
      for (int i = 0; i < len; i++) begin
         tail = cp >> (6 * (len - 1 - i));
         octet.value = (i == 0) ? lead : {2'b10, tail[5:0]};
         octet.run_end = (i == len - 1);
         octet.err = err;
         expected_octets.push_back(octet);
      end
   endfunction

   // Advances the mirrored state by one accepted word and queues its bytes.
   function automatic void predict_word(input logic [31:0] unit, input logic is_last);
      logic        wide;
      logic        mark;
      logic        rmark;
      logic [31:0] raw;
      logic [31:0] u;
      wide = (src_fmt == FMT_UTF32) || (src_fmt == FMT_UCS4);
      raw = wide ? unit : {16'h0000, unit[15:0]};
      if (at_start) begin
         mark = wide ? (raw == BOM_32) : (raw == BOM_16);
         rmark = wide ? (raw == BOM_32_SWAPPED) : (raw == BOM_16_SWAPPED);
         at_start = 1'b0;
         swap_on = 1'b0;
         hi_pending = 1'b0;
         if (mark || rmark) begin
            swap_on = rmark;
            if (is_last) begin
               at_start = 1'b1;
               swap_on = 1'b0;
            end
            return;
         end
      end
      if (!swap_on)
         u = raw;
      else if (wide)
         u = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
      else
         u = {16'h0000, raw[7:0], raw[15:8]};

      if (src_fmt == FMT_UTF16) begin
         if (hi_pending) begin
            hi_pending = 1'b0;
            if (u >= SURR_LOW_LO && u <= SURR_LOW_HI)
               encode_code_point(((32'(hi_bits) << 10) | (u - SURR_LOW_LO)) + SUPPLEMENTARY,
                                 1'b0);
            else
               encode_code_point(CP_REPLACEMENT, 1'b1);
            hi_bits = '0;
         end else if (u < SURR_HIGH_LO || u > SURR_LOW_HI) begin
            encode_code_point(u, 1'b0);
         end else if (u <= SURR_HIGH_HI && !is_last) begin
            hi_pending = 1'b1;
            hi_bits = u[9:0];
         end else begin
            encode_code_point(CP_REPLACEMENT, 1'b1);
         end
      end else begin
         hi_pending = 1'b0;
         hi_bits = '0;
         if (src_fmt == FMT_UTF32 && u >= UNICODE_LIMIT)
            encode_code_point(CP_REPLACEMENT, 1'b1);
         else
            encode_code_point(u, 1'b0);
      end

      if (is_last) begin
         at_start = 1'b1;
         swap_on = 1'b0;
         hi_pending = 1'b0;
         hi_bits = '0;
      end
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(input logic [31:0] unit, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_code_unit <= unit;
      req_last_unit <= is_last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word(unit, is_last);
      words_sent++;
      @(negedge clock);
   endtask

   // Waits for every expected byte, then for words that produce no byte to clear.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_octets.size() != 0) @(negedge clock);
      repeat (PIPE_SETTLE) @(negedge clock);
   endtask

   task automatic write_source_format(input logic [1:0] fmt);
      wait_for_drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= fmt;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      src_fmt = fmt;
      hi_pending = 1'b0;
      hi_bits = '0;
      format_writes++;
   endtask

   // 16-bit formats get random filler in the ignored upper half.
   function automatic logic [31:0] pack_unit(input logic [31:0] v, input logic wide,
                                             input logic swap);
      logic [31:0] filler;
      filler = $urandom;
      if (wide)
         return swap ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
      return {filler[15:0], swap ? {v[7:0], v[15:8]} : v[15:0]};
   endfunction

   function automatic logic [31:0] random_code_point(input logic [1:0] fmt);
      logic [31:0] cp;
      int          pick;
      pick = $urandom_range(9);
      if (fmt == FMT_UCS2 && pick >= 5)
         pick = 4;
      case (pick)
         0, 1, 2: cp = $urandom_range(32'h7F, 32'h0);
         3, 9:    cp = $urandom_range(32'h7FF, 32'h80);
         4: begin
            cp = $urandom_range(32'hFFFF, 32'h800);
            if (cp >= SURR_HIGH_LO && cp <= SURR_LOW_HI)
               cp = cp - 32'h1000;
         end
         5, 6: cp = $urandom_range(32'h10_FFFF, SUPPLEMENTARY);
         default: begin
            if (fmt == FMT_UCS4) begin
               cp = ($urandom & 32'h7FFF_FFFF) >> $urandom_range(20);
               if (cp < UNICODE_LIMIT)
                  cp = cp + UNICODE_LIMIT;
            end else begin
               cp = $urandom_range(32'h10_FFFF, SUPPLEMENTARY);
            end
         end
      endcase
      return cp;
   endfunction

   task automatic send_code_point(input logic [31:0] cp, input logic [1:0] fmt,
                                  input logic swap, input logic is_last);
      logic        wide;
      logic [31:0] offset;
      wide = (fmt == FMT_UTF32) || (fmt == FMT_UCS4);
      if (!wide && cp >= SUPPLEMENTARY) begin
         offset = cp - SUPPLEMENTARY;
         send_word(pack_unit(SURR_HIGH_LO + (offset >> 10), wide, swap), 1'b0);
         send_word(pack_unit(SURR_LOW_LO + offset[9:0], wide, swap), is_last);
      end else begin
         send_word(pack_unit(cp, wide, swap), is_last);
      end
   endtask

   // Mostly well-formed strings, some with a mark; about one slot in seven is noise.
   task automatic send_random_string(input logic [1:0] fmt);
      logic        wide;
      logic        swap;
      logic        slot_last;
      logic [31:0] unit;
      int          len;
      wide = (fmt == FMT_UTF32) || (fmt == FMT_UCS4);
      swap = 1'b0;
      len = $urandom_range(8, 1);
      case ($urandom_range(7))
         0: send_word(pack_unit(wide ? BOM_32 : BOM_16, wide, 1'b0), 1'b0);
         1: begin
            send_word(pack_unit(wide ? BOM_32 : BOM_16, wide, 1'b1), 1'b0);
            swap = 1'b1;
         end
         default: ;
      endcase
      for (int i = 0; i < len; i++) begin
         slot_last = (i == len - 1);
         if ($urandom_range(99) < 15) begin
            case ($urandom_range(3))
               0: unit = $urandom;
               1: unit = pack_unit($urandom_range(SURR_HIGH_HI, SURR_HIGH_LO), wide, swap);
               2: unit = pack_unit($urandom_range(SURR_LOW_HI, SURR_LOW_LO), wide, swap);
               default: unit = pack_unit(random_code_point(fmt), wide, swap);
            endcase
            send_word(unit, slot_last);
         end else begin
            send_code_point(random_code_point(fmt), fmt, swap, slot_last);
         end
      end
   endtask

   task automatic test_utf16_ranges();
      write_source_format(FMT_UTF16);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h0000_007F, 1'b0);
      send_word(32'h0000_0080, 1'b0);
      send_word(32'h0000_07FF, 1'b0);
      send_word(32'hFFFF_0800, 1'b0);
      send_word(32'h0000_FFFF, 1'b1);
   endtask

   task automatic test_utf16_surrogates();
      send_word(32'h0000_D800, 1'b0);
      send_word(32'h0000_DC00, 1'b0);
      send_word(32'h0000_DBFF, 1'b0);
      send_word(32'h0000_DFFF, 1'b0);
      send_word(32'h0000_DC00, 1'b0);
      // A high surrogate followed by a non-low word swallows that word.
      send_word(32'h0000_D83D, 1'b0);
      send_word(32'h0000_0041, 1'b0);
      send_word(32'h0000_D83D, 1'b1);
   endtask

   task automatic test_byte_order_marks();
      send_word(BOM_16, 1'b0);
      send_word(32'h0000_20AC, 1'b0);
      send_word(BOM_16, 1'b1);
      send_word(BOM_16_SWAPPED, 1'b0);
      send_word(32'h0000_AC20, 1'b1);
      send_word(BOM_16, 1'b1);
   endtask

   task automatic test_format_write_drops_high();
      send_word(32'h0000_D800, 1'b0);
      write_source_format(FMT_UTF16);
      send_word(32'h0000_0041, 1'b1);
   endtask

   task automatic test_ucs2();
      write_source_format(FMT_UCS2);
      send_word(32'h0000_D800, 1'b0);
      send_word(32'h0000_FFFF, 1'b1);
   endtask

   task automatic test_wide_formats();
      write_source_format(FMT_UTF32);
      send_word(UNICODE_LIMIT, 1'b0);
      send_word(32'h0010_FFFF, 1'b1);
      send_word(BOM_32_SWAPPED, 1'b0);
      send_word(32'h00F6_0100, 1'b1);
      write_source_format(FMT_UCS4);
      send_word(32'h7FFF_FFFF, 1'b0);
      send_word(32'h8000_0000, 1'b0);
      send_word(32'h0400_0000, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
   endtask

   task automatic test_random_traffic(input int word_target, input int send_pct,
                                      input int rsp_pct);
      int          per_format;
      int          start_count;
      logic [1:0]  fmt;
      send_idle_pct = send_pct;
      rsp_idle_pct = rsp_pct;
      per_format = word_target / 4;
      fmt = 2'($urandom_range(3));
      for (int f = 0; f < 4; f++) begin
         write_source_format(fmt);
         start_count = words_sent;
         while (words_sent - start_count < per_format)
            send_random_string(fmt);
         fmt = fmt + 2'd1;
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      utf8_octet_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_octets.size() == 0) begin
            $error("unexpected byte 0x%02h with nothing expected", rsp_out_byte);
            fail_count++;
         end else begin
            want = expected_octets.pop_front();
            octets_checked++;
            if (rsp_out_byte !== want.value) begin
               $error("out_byte: expected 0x%02h, actual 0x%02h", want.value, rsp_out_byte);
               fail_count++;
            end
            if (rsp_last_of_run !== want.run_end) begin
               $error("last_of_run: expected %0b, actual %0b", want.run_end, rsp_last_of_run);
               fail_count++;
            end
            if (rsp_replacement_error !== want.err) begin
               $error("replacement_error: expected %0b, actual %0b", want.err,
                      rsp_replacement_error);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 20;
      rsp_idle_pct = 61;
      test_utf16_ranges();
      test_utf16_surrogates();
      test_byte_order_marks();
      test_format_write_drops_high();
      test_ucs2();
      test_wide_formats();

      test_random_traffic(156, 20, 61);
      test_random_traffic(156, 61, 20);
      test_random_traffic(156, 0, 0);

      send_idle_pct = 0;
      rsp_idle_pct = 0;
      wait_for_drain();
      $display("Sent %0d code units across all four source formats with %0d format writes.",
               words_sent, format_writes);
      $display("Checked %0d UTF-8 bytes under sender and receiver stalls.", octets_checked);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
